>>> design/mmtc_pkg.sv
`default_nettype none

package mmtc_pkg;

  localparam int WEIGHT_W = 31;
  localparam int TOTAL_W  = 63;

  // datapath operation for the current cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UP_RD,
    OP_UP_CMP,
    OP_POP_RD,
    OP_POP_LD,
    OP_DN_RD,
    OP_DN_CMP,
    OP_MPUSH,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic second;   // second pop of a merge pair
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic up_stop;
    logic pop_empty;
    logic leaf;
    logic dn_stop;
    logic more;       // more than one live entry
    logic out_free;
  } dp_stat_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/mmtc_ifs.sv
`default_nettype none

interface mmtc_in_if import mmtc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                last;

  modport source (output valid, output weight, output last, input ready);
  modport sink   (input valid, input weight, input last, output ready);
endinterface

interface mmtc_out_if import mmtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_cost;
  logic               overflow;

  modport source (output valid, output total_cost, output overflow, input ready);
  modport sink   (input valid, input total_cost, input overflow, output ready);
endinterface

`default_nettype wire

>>> design/mmtc_ctrl.sv
`default_nettype none

module mmtc_ctrl import mmtc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_UP_RD  = 10'b0000000010,
    S_UP_CMP = 10'b0000000100,
    S_MCHK   = 10'b0000001000,
    S_POP_RD = 10'b0000010000,
    S_POP_LD = 10'b0000100000,
    S_DN_RD  = 10'b0001000000,
    S_DN_CMP = 10'b0010000000,
    S_MPUSH  = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   second, second_next;
  logic   last_case, last_case_next;
  state_t push_done;

  assign push_done = last_case ? S_MCHK : S_IDLE;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    second_next    = second;
    last_case_next = last_case;
    cmd.op         = OP_NONE;
    cmd.second     = second;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op         = OP_ACCEPT;
          last_case_next = in_last;
          if (!stat.full) state_next = S_UP_RD;
          else if (in_last) state_next = S_MCHK;
        end
      end
      S_UP_RD: begin
        cmd.op     = OP_UP_RD;
        state_next = stat.idx_zero ? push_done : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op     = OP_UP_CMP;
        state_next = stat.up_stop ? push_done : S_UP_RD;
      end
      S_MCHK: begin
        state_next = stat.more ? S_POP_RD : S_EMIT;
      end
      S_POP_RD: begin
        cmd.op     = OP_POP_RD;
        state_next = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.op = OP_POP_LD;
        if (!stat.pop_empty) state_next = S_DN_RD;
        else if (second) state_next = S_MPUSH;
        else begin
          second_next = 1'b1;
          state_next  = S_POP_RD;
        end
      end
      S_DN_RD: begin
        cmd.op = OP_DN_RD;
        if (!stat.leaf) state_next = S_DN_CMP;
        else if (second) state_next = S_MPUSH;
        else begin
          second_next = 1'b1;
          state_next  = S_POP_RD;
        end
      end
      S_DN_CMP: begin
        cmd.op = OP_DN_CMP;
        if (!stat.dn_stop) state_next = S_DN_RD;
        else if (second) state_next = S_MPUSH;
        else begin
          second_next = 1'b1;
          state_next  = S_POP_RD;
        end
      end
      S_MPUSH: begin
        cmd.op      = OP_MPUSH;
        second_next = 1'b0;
        state_next  = S_UP_RD;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (stat.out_free) begin
          last_case_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      second    <= 1'b0;
      last_case <= 1'b0;
    end else begin
      state     <= state_next;
      second    <= second_next;
      last_case <= last_case_next;
    end
  end

endmodule

`default_nettype wire

>>> design/mmtc_dp.sv
`default_nettype none

module mmtc_dp import mmtc_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TOTAL_W-1:0]  total_cost,
  output logic                overflow
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = AW + 2;

  logic [TOTAL_W-1:0] mem [MAX_ITEMS];
  logic [TOTAL_W-1:0] rd0, rd1;
  logic               we;
  logic [AW-1:0]      wa, ra0, ra1;
  logic [TOTAL_W-1:0] wd;

  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic [TOTAL_W-1:0] val, pick, total;
  logic               dropped;

  logic [AW-1:0]      parent;
  logic [XW-1:0]      c_ix, c1_ix, count_x;
  logic               use_right;
  logic [TOTAL_W-1:0] child_val;
  logic [AW-1:0]      child_ix;
  logic               out_free;

  assign parent    = AW'((idx - 1'b1) >> 1);
  assign c_ix      = XW'({idx, 1'b1});
  assign c1_ix     = c_ix + 1'b1;
  assign count_x   = XW'(count);
  assign use_right = (c1_ix < count_x) && (rd1 < rd0);
  assign child_val = use_right ? rd1 : rd0;
  assign child_ix  = use_right ? c1_ix[AW-1:0] : c_ix[AW-1:0];
  assign out_free  = !out_valid || out_ready;

  assign stat.full      = (count == CW'(MAX_ITEMS));
  assign stat.idx_zero  = (idx == '0);
  assign stat.up_stop   = (rd0 <= val);
  assign stat.pop_empty = (count == '0);
  assign stat.leaf      = (c_ix >= count_x);
  assign stat.dn_stop   = (child_val >= val);
  assign stat.more      = (count > CW'(1));
  assign stat.out_free  = out_free;

  // heap port control
  always_comb begin
    we  = 1'b0;
    wa  = idx;
    wd  = val;
    ra0 = '0;
    ra1 = '0;
    unique case (cmd.op)
      OP_UP_RD: begin
        we  = stat.idx_zero;
        ra0 = parent;
      end
      OP_UP_CMP: begin
        we = 1'b1;
        wd = stat.up_stop ? val : rd0;
      end
      OP_POP_RD: begin
        ra1 = AW'(count - 1'b1);
      end
      OP_DN_RD: begin
        we  = stat.leaf;
        ra0 = c_ix[AW-1:0];
        ra1 = c1_ix[AW-1:0];
      end
      OP_DN_CMP: begin
        we = 1'b1;
        wd = stat.dn_stop ? val : child_val;
      end
      OP_NONE, OP_ACCEPT, OP_POP_LD, OP_MPUSH, OP_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        if (!stat.full) begin
          idx <= AW'(count);
          val <= TOTAL_W'(weight);
        end
      end
      OP_UP_CMP: if (!stat.up_stop) idx <= parent;
      OP_POP_LD: begin
        pick <= cmd.second ? sat_add(pick, rd0) : rd0;
        val  <= rd1;
        idx  <= '0;
      end
      OP_DN_CMP: if (!stat.dn_stop) idx <= child_ix;
      OP_MPUSH: begin
        idx <= AW'(count);
        val <= pick;
      end
      OP_NONE, OP_UP_RD, OP_POP_RD, OP_DN_RD, OP_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      total   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (!stat.full) count <= count + 1'b1;
          else dropped <= 1'b1;
        end
        OP_POP_RD: count <= count - 1'b1;
        OP_MPUSH: begin
          count <= count + 1'b1;
          total <= sat_add(total, pick);
        end
        OP_EMIT: begin
          if (out_free) begin
            count   <= '0;
            total   <= '0;
            dropped <= 1'b0;
          end
        end
        OP_NONE, OP_UP_RD, OP_UP_CMP, OP_POP_LD, OP_DN_RD, OP_DN_CMP: ;
        default: ;
      endcase
    end
  end

  // result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT && out_free) begin
      total_cost <= total;
      overflow   <= dropped;
    end
  end

endmodule

`default_nettype wire

>>> design/min_merge_total_cost.sv
// Non-final beat: accepted in idle, then sifted up by a read and a compare per heap
// level climbed, up to the root or a parent that is not larger; a beat dropped on a
// full heap is only accepted. Final beat: its insert unless the heap is full, then per
// merge a check, two pops (each a read and load, then a read and compare per level
// descended) and a reinsert; the result register loads once the previous result is taken.
// Synchronous active-high reset empties the heap and clears total, overflow and valid.
`default_nettype none

module min_merge_total_cost import mmtc_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input  logic      clk,
  input  logic      rst,
  mmtc_in_if.sink   in_ch,
  mmtc_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  mmtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmtc_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .weight     (in_ch.weight),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .total_cost (out_ch.total_cost),
    .overflow   (out_ch.overflow)
  );

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.last) |=> !in_ch.ready)
    else $error("input taken right after a final beat");

  a_merge_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MPUSH) |-> !stat.full)
    else $error("merge reinsert into a full heap");

  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT && stat.out_free) |=> out_ch.valid)
    else $error("result not presented after emit");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (cmd.op == OP_ACCEPT))
    else $error("input beat taken outside accept");

endmodule

`default_nettype wire

>>> sim/tb.sv
module tb;
  import mmtc_pkg::*;

  localparam int CAPACITY = 256;
  localparam int ITEMS = 1450;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 2500;
  localparam logic [63:0] COST_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WMAX = {WEIGHT_W{1'b1}};

  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               ovf;
  } cost_t;

  typedef struct {
    logic [WEIGHT_W-1:0] w;
    logic                l;
    logic                typed;
    logic [TOTAL_W-1:0]  total;
    logic                ovf;
  } row_t;

  typedef enum int {WM_FULL, WM_SMALL, WM_EDGE, WM_ONEHOT} wmode_t;

  logic clk = 1'b0;
  logic rst;

  mmtc_in_if  in_ch ();
  mmtc_out_if out_ch ();

  min_merge_total_cost i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // weights of the open case, unordered; the two smallest are picked by scan
  logic [63:0] pool [CAPACITY];
  int          pool_n = 0;
  logic        dropped = 1'b0;
  cost_t       cost_q [$];

  int err_cnt = 0;
  int sent = 0;
  int results_seen = 0;
  logic calm = 1'b0;

  // directed cases; typed totals only where obvious
  row_t plan [18] = '{
    '{31'd0, 1'b1, 1'b1, 63'd0, 1'b0},
    '{WMAX,  1'b1, 1'b1, 63'd0, 1'b0},
    '{WMAX,  1'b0, 1'b0, 63'd0, 1'b0},
    '{WMAX,  1'b1, 1'b1, 63'd4294967294, 1'b0},
    '{31'd0, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd0, 1'b1, 1'b1, 63'd0, 1'b0},
    '{31'd1, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd2, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd3, 1'b1, 1'b0, 63'd0, 1'b0},
    '{31'h5555_5555, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'h2AAA_AAAA, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd7,  1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd0,  1'b0, 1'b0, 63'd0, 1'b0},
    '{WMAX,   1'b1, 1'b0, 63'd0, 1'b0},
    '{31'd1000, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd1000, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd1000, 1'b0, 1'b0, 63'd0, 1'b0},
    '{31'd1000, 1'b1, 1'b0, 63'd0, 1'b0}
  };

  function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b);
    if (a > COST_MAX || b > COST_MAX - a) return COST_MAX;
    return a + b;
  endfunction

  task automatic take_min(output logic [63:0] v);
    int k;
    k = 0;
    for (int j = 1; j < pool_n; j++) if (pool[j] < pool[k]) k = j;
    v = pool[k];
    pool[k] = pool[pool_n-1];
    pool_n--;
  endtask

  // add one weight to the open case; on the last beat merge and queue the cost
  task automatic absorb_weight(input logic [WEIGHT_W-1:0] w, input logic l,
                               input logic typed, input cost_t typed_res);
    logic [63:0] a, b, s, total;
    cost_t res;
    if (pool_n < CAPACITY) begin
      pool[pool_n] = {33'd0, w};
      pool_n++;
    end else begin
      dropped = 1'b1;
    end
    if (l) begin
      total = 64'd0;
      while (pool_n > 1) begin
        take_min(a);
        take_min(b);
        s = clip_add(a, b);
        total = clip_add(total, s);
        pool[pool_n] = s;
        pool_n++;
      end
      res.total = total[TOTAL_W-1:0];
      res.ovf = dropped;
      cost_q.push_back(typed ? typed_res : res);
      pool_n = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic send_beat(input logic [WEIGHT_W-1:0] w, input logic l,
                           input logic typed, input cost_t typed_res);
    while (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.weight <= w;
    in_ch.last   <= l;
    do @(posedge clk); while (!in_ch.ready);
    absorb_weight(w, l, typed, typed_res);
    sent++;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight(input wmode_t m);
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(7) == 0) return r[WEIGHT_W-1:0];
    case (m)
      WM_SMALL:  return WEIGHT_W'($urandom_range(15));
      WM_EDGE:   return r[0] ? WMAX : (r[1] ? '0 : WMAX - WEIGHT_W'(r[3:2]));
      WM_ONEHOT: return WEIGHT_W'(1) << $urandom_range(WEIGHT_W-1);
      default:   return r[WEIGHT_W-1:0];
    endcase
  endfunction

  task automatic run_case(input int n, input wmode_t m);
    cost_t none;
    none = '{'0, 1'b0};
    for (int i = 0; i < n; i++) send_beat(pick_weight(m), i == n - 1, 1'b0, none);
  endtask

  // result side: random ready, one long hold-off once the traffic is going
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (results_seen == 12) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cost_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (cost_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat total=%0d overflow=%0b",
                                  out_ch.total_cost, out_ch.overflow));
      end else begin
        want = cost_q.pop_front();
        if (out_ch.total_cost !== want.total)
          report_mismatch($sformatf("total_cost %0d, want %0d", out_ch.total_cost, want.total));
        if (out_ch.overflow !== want.ovf)
          report_mismatch($sformatf("overflow %0b, want %0b", out_ch.overflow, want.ovf));
      end
    end
  end

  // stall watchdog: cycles without any beat on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int case_no;
    int n;
    int pick;
    cost_t typed_res;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.weight = '0;
    in_ch.last = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      typed_res = '{plan[r].total, plan[r].ovf};
      send_beat(plan[r].w, plan[r].l, plan[r].typed, typed_res);
    end

    // mostly short cases; three long ones hit the full store
    case_no = 0;
    while (sent < ITEMS) begin
      case_no++;
      calm = (sent >= 300 && sent < 500);
      pick = $urandom_range(99);
      if (case_no == 20)      n = CAPACITY;
      else if (case_no == 40) n = CAPACITY + 1;
      else if (case_no == 60) n = CAPACITY + 14;
      else if (pick < 75)     n = $urandom_range(1, 6);
      else if (pick < 97)     n = $urandom_range(7, 30);
      else                    n = $urandom_range(31, 100);
      run_case(n, wmode_t'($urandom_range(3)));
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (cost_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> min_merge_total_cost.f
design/mmtc_pkg.sv
design/mmtc_ifs.sv
design/mmtc_ctrl.sv
design/mmtc_dp.sv
design/min_merge_total_cost.sv
sim/tb.sv
